// ===== hdl/fvm_pkg.sv =====
// Shared types, constants and helper functions of the FOC voltage modulator.
// Used by every module under hdl/; depends on nothing else.
package fvm_pkg;

   localparam int ANGLE_W = 12;
   localparam int TURN_W  = 20;
   localparam int VOLT_W  = 16;
   localparam int DUTY_W  = 9;
   localparam int POS_W   = 32;
   localparam int PP_W    = 7;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 33;
   localparam int PHASE_W = 35;
   localparam int NUM_W   = 31;
   localparam int SINE_W  = 15;

   localparam logic [PP_W-1:0]    PAIR_COUNT_RESET  = 7'd7;
   localparam logic               REVERSE_RESET     = 1'b0;
   localparam logic [ANGLE_W-1:0] ZERO_OFFSET_RESET = 12'd156;

   localparam logic signed [ANGLE_W:0] TURN_JUMP    = 13'sd3200;
   localparam logic [ANGLE_W-1:0]      QUARTER_TURN = 12'd1024;

   localparam logic signed [MUL_B_W-1:0] SQRT3_HALF_Q16 = 18'sd56756;
   localparam logic signed [MUL_B_W-1:0] PWM_PERIOD     = 18'sd500;
   localparam logic signed [MUL_B_W-1:0] DIV3_RECIP     = 18'sd43691;
   localparam logic signed [PROD_W-1:0]  ROUND_Q15      = 51'sd16384;

   localparam logic signed [PHASE_W-1:0] SIX_VOLT_Q27 = 35'sd805306368;
   localparam logic signed [PHASE_W-1:0] FULL_Q27     = 35'sd1610612736;
   localparam logic [NUM_W-1:0]          NUM_MAX      = 31'd1610612736;
   localparam logic [DUTY_W-1:0]         DUTY_MAX     = 9'd500;
   localparam logic [SINE_W-1:0]         SINE_ONE     = 15'd16384;

   typedef enum logic [1:0] {
      REG_PAIR_COUNT  = 2'd0,
      REG_REVERSE     = 2'd1,
      REG_ZERO_OFFSET = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ANGLE,
      S_ELEC,
      S_SIN_LU,
      S_SIN_MUL,
      S_COS_MUL,
      S_ALPHA_1,
      S_ALPHA_2,
      S_BETA_1,
      S_BETA_2,
      S_BETA_3,
      S_SCALE,
      S_ROUND,
      S_PHASE,
      S_DUTY_MUL,
      S_DUTY_DIV,
      S_DUTY_STORE,
      S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [PP_W-1:0]    pair_count;
      logic               reverse;
      logic [ANGLE_W-1:0] zero_offset;
   } cfg_type;

   typedef struct packed {
      logic [SINE_W-1:0] base;
      logic [9:0]        delta;
      logic [4:0]        frac;
      logic              top;
      logic              neg;
   } lu_type;

   // Quarter-wave sine, Q1.14, one entry every 32 counts
   function automatic logic [SINE_W-1:0] sine_entry(input logic [5:0] i);
      logic [SINE_W-1:0] v;
      case (i)
         6'd0:  v = 15'd0;
         6'd1:  v = 15'd804;
         6'd2:  v = 15'd1606;
         6'd3:  v = 15'd2404;
         6'd4:  v = 15'd3196;
         6'd5:  v = 15'd3981;
         6'd6:  v = 15'd4756;
         6'd7:  v = 15'd5520;
         6'd8:  v = 15'd6270;
         6'd9:  v = 15'd7005;
         6'd10: v = 15'd7723;
         6'd11: v = 15'd8423;
         6'd12: v = 15'd9102;
         6'd13: v = 15'd9760;
         6'd14: v = 15'd10394;
         6'd15: v = 15'd11003;
         6'd16: v = 15'd11585;
         6'd17: v = 15'd12140;
         6'd18: v = 15'd12665;
         6'd19: v = 15'd13160;
         6'd20: v = 15'd13623;
         6'd21: v = 15'd14053;
         6'd22: v = 15'd14449;
         6'd23: v = 15'd14811;
         6'd24: v = 15'd15137;
         6'd25: v = 15'd15426;
         6'd26: v = 15'd15679;
         6'd27: v = 15'd15893;
         6'd28: v = 15'd16069;
         6'd29: v = 15'd16207;
         6'd30: v = 15'd16305;
         6'd31: v = 15'd16364;
         default: v = SINE_ONE;
      endcase
      return v;
   endfunction

   // Fold the angle into the first quadrant and fetch the two neighbors
   function automatic lu_type sine_lookup(input logic [ANGLE_W-1:0] a);
      logic [10:0] idx;
      logic [5:0]  i;
      lu_type      lu;
      idx = a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
      i = idx[10:5];
      lu.base  = sine_entry(i);
      lu.delta = 10'(sine_entry(i + 6'd1) - sine_entry(i));
      lu.frac  = idx[4:0];
      lu.top   = idx[10];
      lu.neg   = a[11];
      return lu;
   endfunction

   // Add the rounded interpolation term and apply the half-turn sign
   function automatic logic signed [VOLT_W-1:0] sine_finish(input lu_type lu,
                                                            input logic [15:0] p);
      logic [SINE_W-1:0] v;
      logic [VOLT_W-1:0] sv;
      v  = lu.top ? SINE_ONE : lu.base + SINE_W'((p + 16'd16) >> 5);
      sv = {1'b0, v};
      return lu.neg ? -$signed(sv) : $signed(sv);
   endfunction

   // Shift a phase voltage up by 6 V and clamp to 0..12 V
   function automatic logic [NUM_W-1:0] clamp_num(input logic signed [PHASE_W-1:0] ph);
      logic signed [PHASE_W-1:0] sum;
      logic [NUM_W-1:0]          n;
      sum = ph + SIX_VOLT_Q27;
      if (sum < 0) begin
         n = '0;
      end else if (sum > FULL_Q27) begin
         n = NUM_MAX;
      end else begin
         n = sum[NUM_W-1:0];
      end
      return n;
   endfunction

endpackage

// ===== hdl/fvm_if.sv =====
// Request and response channel interfaces of the FOC voltage modulator.
// Stand-alone; the payload widths follow the channel field list.
interface fvm_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        encoder_count;
   logic signed [15:0] volt_q;
   logic signed [15:0] volt_d;

   modport source (output valid, output encoder_count, output volt_q, output volt_d,
                   input ready);
   modport sink (input valid, input encoder_count, input volt_q, input volt_d,
                 output ready);
endinterface

interface fvm_rsp_if;
   logic               valid;
   logic               ready;
   logic [8:0]         duty_u;
   logic [8:0]         duty_v;
   logic [8:0]         duty_w;
   logic [11:0]        elec_angle;
   logic signed [31:0] position;

   modport source (output valid, output duty_u, output duty_v, output duty_w,
                   output elec_angle, output position, input ready);
   modport sink (input valid, input duty_u, input duty_v, input duty_w,
                 input elec_angle, input position, output ready);
endinterface

// ===== hdl/fvm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on fvm_pkg for operand widths.
module fvm_mul (
   input  logic                                 clock,
   input  logic signed [fvm_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [fvm_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [fvm_pkg::PROD_W-1:0]    prod
);
   import fvm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/fvm_csr.sv =====
// APB-style configuration registers: pole pairs, reverse, zero offset.
// Depends on fvm_pkg for the register map and the config struct.
module fvm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fvm_pkg::PADDR_W-1:0]   paddr,
   input  logic [fvm_pkg::PDATA_W-1:0]   pwdata,
   output logic [fvm_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output fvm_pkg::cfg_type              cfg
);
   import fvm_pkg::*;

   logic [PP_W-1:0]    pair_count_ff, pair_count_in;
   logic               reverse_ff, reverse_in;
   logic [ANGLE_W-1:0] zero_offset_ff, zero_offset_in;
   logic               wr_en;
   reg_index_type      reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[3:2]);

   always_comb begin
      pair_count_in  = pair_count_ff;
      reverse_in     = reverse_ff;
      zero_offset_in = zero_offset_ff;
      prdata         = '0;
      case (reg_sel)
         REG_PAIR_COUNT: begin
            prdata = PDATA_W'(pair_count_ff);
            if (wr_en) begin
               pair_count_in = pwdata[PP_W-1:0];
            end
         end
         REG_REVERSE: begin
            prdata = PDATA_W'(reverse_ff);
            if (wr_en) begin
               reverse_in = pwdata[0];
            end
         end
         REG_ZERO_OFFSET: begin
            prdata = PDATA_W'(zero_offset_ff);
            if (wr_en) begin
               zero_offset_in = pwdata[ANGLE_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff  <= PAIR_COUNT_RESET;
         reverse_ff     <= REVERSE_RESET;
         zero_offset_ff <= ZERO_OFFSET_RESET;
      end else begin
         pair_count_ff  <= pair_count_in;
         reverse_ff     <= reverse_in;
         zero_offset_ff <= zero_offset_in;
      end
   end

   assign cfg.pair_count  = pair_count_ff;
   assign cfg.reverse     = reverse_ff;
   assign cfg.zero_offset = zero_offset_ff;

endmodule

// ===== hdl/fvm_core.sv =====
// Sequencer and datapath: angle tracking, sine lookup, inverse Park/Clarke, duty.
// Depends on fvm_pkg, the fvm_req_if/fvm_rsp_if channels and fvm_mul.
module fvm_core (
   input  logic               clock,
   input  logic               reset,
   input  fvm_pkg::cfg_type   cfg,
   fvm_req_if.sink            req,
   fvm_rsp_if.source          rsp
);
   import fvm_pkg::*;

   fsm_state_type             state_ff, state_in;
   logic [ANGLE_W-1:0]        enc_ff, enc_in;
   logic signed [VOLT_W-1:0]  vq_ff, vq_in;
   logic signed [VOLT_W-1:0]  vd_ff, vd_in;
   logic [ANGLE_W-1:0]        ang_ff, ang_in;
   logic [ANGLE_W-1:0]        last_angle_ff, last_angle_in;
   logic [TURN_W-1:0]         turn_ff, turn_in;
   logic [ANGLE_W-1:0]        elec_ff, elec_in;
   lu_type                    lu_sin_ff, lu_sin_in;
   lu_type                    lu_cos_ff, lu_cos_in;
   logic signed [VOLT_W-1:0]  sn_ff, sn_in;
   logic signed [VOLT_W-1:0]  cs_ff, cs_in;
   logic signed [ACC_W-1:0]   alpha_ff, alpha_in;
   logic signed [ACC_W-1:0]   beta_ff, beta_in;
   logic signed [ACC_W-1:0]   s_ff, s_in;
   logic [NUM_W-1:0]          num_ff [3];
   logic [NUM_W-1:0]          num_in [3];
   logic [1:0]                idx_ff, idx_in;
   logic [DUTY_W-1:0]         duty_ff [3];
   logic [DUTY_W-1:0]         duty_in [3];
   logic [DUTY_W-1:0]         out_duty_ff [3];
   logic [DUTY_W-1:0]         out_duty_in [3];
   logic [ANGLE_W-1:0]        out_elec_ff, out_elec_in;
   logic [POS_W-1:0]          out_pos_ff, out_pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [ANGLE_W-1:0]        ang_calc;
   logic signed [ANGLE_W:0]   ang_diff;
   logic signed [PROD_W-1:0]  rnd_sum;
   logic signed [PHASE_W-1:0] alpha_x;
   logic signed [PHASE_W-1:0] s_x;

   fvm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign ang_calc = cfg.reverse ? (cfg.zero_offset - enc_ff) : (enc_ff - cfg.zero_offset);
   assign ang_diff = $signed({1'b0, ang_calc}) - $signed({1'b0, last_angle_ff});
   assign rnd_sum  = prod + ROUND_Q15;
   assign alpha_x  = {{(PHASE_W-ACC_W){alpha_ff[ACC_W-1]}}, alpha_ff};
   assign s_x      = {{(PHASE_W-ACC_W){s_ff[ACC_W-1]}}, s_ff};

   always_comb begin
      state_in      = state_ff;
      enc_in        = enc_ff;
      vq_in         = vq_ff;
      vd_in         = vd_ff;
      ang_in        = ang_ff;
      last_angle_in = last_angle_ff;
      turn_in       = turn_ff;
      elec_in       = elec_ff;
      lu_sin_in     = lu_sin_ff;
      lu_cos_in     = lu_cos_ff;
      sn_in         = sn_ff;
      cs_in         = cs_ff;
      alpha_in      = alpha_ff;
      beta_in       = beta_ff;
      s_in          = s_ff;
      num_in        = num_ff;
      idx_in        = idx_ff;
      duty_in       = duty_ff;
      out_duty_in   = out_duty_ff;
      out_elec_in   = out_elec_ff;
      out_pos_in    = out_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      mul_a         = '0;
      mul_b         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               enc_in   = req.encoder_count;
               vq_in    = req.volt_q;
               vd_in    = req.volt_d;
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            // step the turn counter on a wrap, then form angle times pole pairs
            ang_in        = ang_calc;
            last_angle_in = ang_calc;
            if (ang_diff > TURN_JUMP) begin
               turn_in = turn_ff - 20'd1;
            end else if (ang_diff < -TURN_JUMP) begin
               turn_in = turn_ff + 20'd1;
            end
            mul_a    = {{(MUL_A_W-ANGLE_W){1'b0}}, ang_calc};
            mul_b    = {{(MUL_B_W-PP_W){1'b0}}, cfg.pair_count};
            state_in = S_ELEC;
         end
         S_ELEC: begin
            elec_in  = prod[ANGLE_W-1:0];
            state_in = S_SIN_LU;
         end
         S_SIN_LU: begin
            lu_sin_in = sine_lookup(elec_ff);
            lu_cos_in = sine_lookup(elec_ff + QUARTER_TURN);
            state_in  = S_SIN_MUL;
         end
         S_SIN_MUL: begin
            mul_a    = {{(MUL_A_W-10){1'b0}}, lu_sin_ff.delta};
            mul_b    = {{(MUL_B_W-5){1'b0}}, lu_sin_ff.frac};
            state_in = S_COS_MUL;
         end
         S_COS_MUL: begin
            sn_in    = sine_finish(lu_sin_ff, prod[15:0]);
            mul_a    = {{(MUL_A_W-10){1'b0}}, lu_cos_ff.delta};
            mul_b    = {{(MUL_B_W-5){1'b0}}, lu_cos_ff.frac};
            state_in = S_ALPHA_1;
         end
         S_ALPHA_1: begin
            cs_in    = sine_finish(lu_cos_ff, prod[15:0]);
            mul_a    = {{(MUL_A_W-VOLT_W){vq_ff[VOLT_W-1]}}, vq_ff};
            mul_b    = {{(MUL_B_W-VOLT_W){sn_ff[VOLT_W-1]}}, sn_ff};
            state_in = S_ALPHA_2;
         end
         S_ALPHA_2: begin
            alpha_in = -prod[ACC_W-1:0];
            mul_a    = {{(MUL_A_W-VOLT_W){vd_ff[VOLT_W-1]}}, vd_ff};
            mul_b    = {{(MUL_B_W-VOLT_W){cs_ff[VOLT_W-1]}}, cs_ff};
            state_in = S_BETA_1;
         end
         S_BETA_1: begin
            alpha_in = alpha_ff + $signed(prod[ACC_W-1:0]);
            mul_a    = {{(MUL_A_W-VOLT_W){vd_ff[VOLT_W-1]}}, vd_ff};
            mul_b    = {{(MUL_B_W-VOLT_W){sn_ff[VOLT_W-1]}}, sn_ff};
            state_in = S_BETA_2;
         end
         S_BETA_2: begin
            beta_in  = prod[ACC_W-1:0];
            mul_a    = {{(MUL_A_W-VOLT_W){vq_ff[VOLT_W-1]}}, vq_ff};
            mul_b    = {{(MUL_B_W-VOLT_W){cs_ff[VOLT_W-1]}}, cs_ff};
            state_in = S_BETA_3;
         end
         S_BETA_3: begin
            beta_in  = beta_ff + $signed(prod[ACC_W-1:0]);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            mul_a    = beta_ff;
            mul_b    = SQRT3_HALF_Q16;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            // round half up, floor on the arithmetic shift
            s_in     = rnd_sum[15 +: ACC_W];
            state_in = S_PHASE;
         end
         S_PHASE: begin
            num_in[0] = clamp_num(alpha_x + alpha_x);
            num_in[1] = clamp_num(s_x - alpha_x);
            num_in[2] = clamp_num(-alpha_x - s_x);
            idx_in    = 2'd0;
            state_in  = S_DUTY_MUL;
         end
         S_DUTY_MUL: begin
            mul_a    = {{(MUL_A_W-NUM_W){1'b0}}, num_ff[idx_ff]};
            mul_b    = PWM_PERIOD;
            state_in = S_DUTY_DIV;
         end
         S_DUTY_DIV: begin
            // divide by 12 V: shift out 2^29, then times reciprocal of three
            mul_a    = {{(MUL_A_W-11){1'b0}}, prod[39:29]};
            mul_b    = DIV3_RECIP;
            state_in = S_DUTY_STORE;
         end
         S_DUTY_STORE: begin
            duty_in[idx_ff] = prod[25:17];
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_DUTY_MUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_duty_in  = duty_ff;
               out_elec_in  = elec_ff;
               out_pos_in   = {turn_ff, ang_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_angle_ff <= '0;
         turn_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_angle_ff <= last_angle_in;
         turn_ff       <= turn_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      enc_in_reg: begin
         enc_ff      <= enc_in;
         vq_ff       <= vq_in;
         vd_ff       <= vd_in;
         ang_ff      <= ang_in;
         elec_ff     <= elec_in;
         lu_sin_ff   <= lu_sin_in;
         lu_cos_ff   <= lu_cos_in;
         sn_ff       <= sn_in;
         cs_ff       <= cs_in;
         alpha_ff    <= alpha_in;
         beta_ff     <= beta_in;
         s_ff        <= s_in;
         num_ff      <= num_in;
         duty_ff     <= duty_in;
         out_duty_ff <= out_duty_in;
         out_elec_ff <= out_elec_in;
         out_pos_ff  <= out_pos_in;
      end
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.duty_u     = out_duty_ff[0];
   assign rsp.duty_v     = out_duty_ff[1];
   assign rsp.duty_w     = out_duty_ff[2];
   assign rsp.elec_angle = out_elec_ff;
   assign rsp.position   = $signed(out_pos_ff);

   a_turn_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_ANGLE |=> $stable(turn_ff))
      else $error("turn count changed outside the angle step");

   a_turn_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ANGLE |=> (turn_ff == $past(turn_ff) ||
                               turn_ff == $past(turn_ff) + 20'd1 ||
                               turn_ff == $past(turn_ff) - 20'd1))
      else $error("turn count stepped by more than one");

   a_num_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUTY_MUL |-> num_ff[idx_ff] <= NUM_MAX)
      else $error("phase numerator beyond full scale");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_duty_ff[0] <= DUTY_MAX && out_duty_ff[1] <= DUTY_MAX &&
                        out_duty_ff[2] <= DUTY_MAX))
      else $error("compare value beyond PWM period");

endmodule

// ===== hdl/foc_voltage_modulator.sv =====
// Top level of the FOC voltage modulator: config registers plus sequenced core.
// Depends on fvm_pkg, fvm_if (channels), fvm_csr and fvm_core.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | valid/ready          | encoder_count, volt_q, volt_d
//   rsp     | out       | valid/ready          | duty_u, duty_v, duty_w, elec_angle, position
//   csr     | in        | psel/penable/pready  | paddr, pwdata (write), prdata (read)
//
// Each request passes through the accept cycle, 22 sequencer steps that feed
// 14 products (electrical angle, two sine interpolations, four Park terms, the sqrt(3)/2
// scale, and two per compare value) through one registered multiplier, and the hand-off
// cycle, which loads the output register. Ready stays low from acceptance until then.
// Reset is synchronous and active high; it restores the register defaults and clears the
// turn counter and the previous angle. A stalled response holds in the output register;
// the next request is accepted meanwhile and waits in the hand-off step until it drains.
module foc_voltage_modulator (
   input  logic                          clock,
   input  logic                          reset,
   fvm_req_if.sink                       req,
   fvm_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fvm_pkg::PADDR_W-1:0]   paddr,
   input  logic [fvm_pkg::PDATA_W-1:0]   pwdata,
   output logic [fvm_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import fvm_pkg::*;

   cfg_type cfg;

   // register file: pole pairs, direction, zero offset
   fvm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer around the shared multiplier; holds turn state and the response
   fvm_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

// ===== tb/tb_foc_voltage_modulator.sv =====
// Self-checking testbench of the FOC voltage modulator (foc_voltage_modulator).
// Depends on fvm_pkg, the channel interfaces in fvm_if and the block's RTL under hdl/.
// Directed turn-counter and register corners, then three random traffic phases.
`timescale 1ns / 100ps

module tb_foc_voltage_modulator;
   import fvm_pkg::*;

   // Unlisted register slot: writes there must change nothing
   localparam int unsigned UNUSED_REG_INDEX = 3;

   // Turn-step threshold and Q27 voltage span of the compare mapping
   localparam int     JUMP_COUNTS   = 3200;
   localparam longint SIX_VOLTS     = 64'sd805306368;
   localparam longint TWELVE_VOLTS  = 64'sd1610612736;
   localparam longint PERIOD_COUNTS = 64'sd500;
   localparam longint ROOT3_HALF    = 64'sd56756;

   // Quarter-wave sine in Q14, one entry every 32 counts
   localparam int SINE_Q14 [0:32] = '{
      0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
      6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
      11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
      15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
      16384
   };

   typedef struct {
      logic [DUTY_W-1:0]       duty_u;
      logic [DUTY_W-1:0]       duty_v;
      logic [DUTY_W-1:0]       duty_w;
      logic [ANGLE_W-1:0]      elec_angle;
      logic signed [POS_W-1:0] position;
   } pwm_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   fvm_req_if req_bus ();
   fvm_rsp_if rsp_bus ();

   foc_voltage_modulator dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the block's registers and rotor tracking state
   logic [PP_W-1:0]    pair_count_now;
   logic               reverse_now;
   logic [ANGLE_W-1:0] zero_offset_now;
   logic [ANGLE_W-1:0] prev_angle;
   logic [TURN_W-1:0]  turn_total;

   // Compare values awaiting their response, oldest first
   pwm_result_type pwm_queue [$];

   int send_idle_pct = 25;
   int recv_idle_pct = 86;
   int error_count     = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int reg_writes      = 0;

   // 10 ns period: half high, half low
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("tb_foc_voltage_modulator: done, errors");
      $finish;
   end

   // Stall the response channel at random; the rate changes per phase
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Interpolated sine in Q14, sign from the half turn
   function automatic longint sine_at(input logic [ANGLE_W-1:0] a);
      logic [10:0] idx;
      int          i;
      int          f;
      int          v;
      idx = a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
      i = idx[10:5];
      f = idx[4:0];
      if (i >= 32) begin
         v = SINE_Q14[32];
      end else begin
         v = SINE_Q14[i] + (((SINE_Q14[i+1] - SINE_Q14[i]) * f + 16) >>> 5);
      end
      return a[11] ? -longint'(v) : longint'(v);
   endfunction

   // Offset the phase by 6 V, clamp to 0..12 V and scale onto the PWM period
   function automatic logic [DUTY_W-1:0] compare_value(input longint phase);
      longint num;
      num = phase + SIX_VOLTS;
      if (num < 0) begin
         num = 0;
      end
      if (num > TWELVE_VOLTS) begin
         num = TWELVE_VOLTS;
      end
      return DUTY_W'(num * PERIOD_COUNTS / TWELVE_VOLTS);
   endfunction

   // Advance the rotor tracking and work out the three compare values
   function automatic pwm_result_type modulate_request(input logic [ANGLE_W-1:0] enc,
                                                       input logic signed [VOLT_W-1:0] vq,
                                                       input logic signed [VOLT_W-1:0] vd);
      logic [ANGLE_W-1:0] ang;
      logic [ANGLE_W-1:0] elec;
      int                 diff;
      longint             q, d, sn, cs, alpha, beta, s, turns;
      pwm_result_type     r;
      ang = reverse_now ? ANGLE_W'(zero_offset_now - enc) : ANGLE_W'(enc - zero_offset_now);
      diff = int'(ang) - int'(prev_angle);
      if (diff > JUMP_COUNTS) begin
         turn_total = turn_total - 1'b1;
      end else if (diff < -JUMP_COUNTS) begin
         turn_total = turn_total + 1'b1;
      end
      prev_angle = ang;

      elec  = ANGLE_W'(32'(ang) * 32'(pair_count_now));
      q     = vq;
      d     = vd;
      sn    = sine_at(elec);
      cs    = sine_at(ANGLE_W'(elec + 12'd1024));
      alpha = d * cs - q * sn;
      beta  = d * sn + q * cs;
      s     = (beta * ROOT3_HALF + 64'sd16384) >>> 15;

      turns = $signed(turn_total);
      r.duty_u     = compare_value(2 * alpha);
      r.duty_v     = compare_value(-alpha + s);
      r.duty_w     = compare_value(-alpha - s);
      r.elec_angle = elec;
      r.position   = POS_W'(turns * 4096 + longint'(ang));
      return r;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
                  $time, field, results_checked, want, got);
         error_count++;
      end
   endtask

   // Compare every accepted response with the oldest prediction
   always @(posedge clock) begin : response_check
      pwm_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pwm_queue.size() == 0) begin
            $display("%0t: response with none expected: expected nothing, actual u=%0d v=%0d",
                     $time, rsp_bus.duty_u, rsp_bus.duty_v);
            error_count++;
         end else begin
            want = pwm_queue.pop_front();
            check_field("duty_u", want.duty_u, rsp_bus.duty_u);
            check_field("duty_v", want.duty_v, rsp_bus.duty_v);
            check_field("duty_w", want.duty_w, rsp_bus.duty_w);
            check_field("elec_angle", want.elec_angle, rsp_bus.elec_angle);
            check_field("position", want.position, rsp_bus.position);
         end
         results_checked++;
      end
   end

   // Present one request, hold it until accepted, then predict its response.
   // valid is left high on return so back-to-back requests need no extra edge.
   task automatic send_request(input logic [ANGLE_W-1:0] enc,
                               input logic signed [VOLT_W-1:0] vq,
                               input logic signed [VOLT_W-1:0] vd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.encoder_count <= enc;
      req_bus.volt_q        <= vq;
      req_bus.volt_d        <= vd;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      pwm_queue.push_back(modulate_request(enc, vq, vd));
      requests_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every predicted response has drained
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pwm_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready
   task automatic write_reg(input int unsigned index, input logic [PDATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(index * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      case (index)
         REG_PAIR_COUNT:  pair_count_now  = value[PP_W-1:0];
         REG_REVERSE:     reverse_now     = value[0];
         REG_ZERO_OFFSET: zero_offset_now = value[ANGLE_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Pick a new register setting, favoring the corners; junk in unused bits
   task automatic randomize_config();
      logic [PP_W-1:0]    pp;
      logic [ANGLE_W-1:0] offset;
      case ($urandom_range(5))
         0: pp = 7'd0;
         1: pp = 7'd1;
         2: pp = 7'd64;
         3: pp = 7'd127;
         default: pp = PP_W'($urandom_range(64, 1));
      endcase
      case ($urandom_range(3))
         0: offset = '0;
         1: offset = '1;
         default: offset = ANGLE_W'($urandom);
      endcase
      write_reg(REG_PAIR_COUNT, ($urandom & ~32'h7F) | 32'(pp));
      write_reg(REG_REVERSE, ($urandom & ~32'h1) | 32'($urandom_range(1)));
      write_reg(REG_ZERO_OFFSET, ($urandom & ~32'hFFF) | 32'(offset));
   endtask

   // Voltage command: full range, linear band, rails, or near the clamp points
   function automatic logic signed [VOLT_W-1:0] pick_volt();
      logic signed [VOLT_W-1:0] v;
      case ($urandom_range(3))
         0: v = VOLT_W'($urandom);
         1: v = VOLT_W'(int'($urandom_range(12000)) - 6000);
         2: v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: v = VOLT_W'(int'($urandom_range(49152)) - 24576);
      endcase
      return v;
   endfunction

   // Turn counter around its threshold, both wrap directions, voltage rails.
   // At the reset offset the corrected angle is count - 156.
   task automatic test_turn_tracking();
      send_request(12'd156,  16'sh7FFF, 16'sh8000);  // angle 0, no move
      send_request(12'd3356, 16'sh8000, 16'sh7FFF);  // jump of exactly +3200: hold
      send_request(12'd156,  16'sd0,    16'sd0);     // jump of exactly -3200: hold
      send_request(12'd3357, 16'sh7FFF, 16'sh7FFF);  // +3201: step back one turn
      send_request(12'd156,  16'sh8000, 16'sh8000);  // -3201: step forward again
      send_request(12'd155,  16'sd12288, 16'sd0);    // wrap below zero: negative position
      send_request(12'd157,  16'sd0,   -16'sd12288); // wrap back across zero
      send_request(12'd4095, 16'sd24576, 16'sd0);    // exactly at the 6 V rail
   endtask

   // Quadrant edges, zero and maximum pole pairs, reversed direction, unused slot
   task automatic test_register_corners();
      settle();
      write_reg(REG_PAIR_COUNT, 32'd1);
      write_reg(REG_REVERSE, 32'd0);
      write_reg(REG_ZERO_OFFSET, 32'd0);
      send_request(12'd0,    16'sd8192, -16'sd4096);
      send_request(12'd1024, 16'sd8192, -16'sd4096);  // sine lands on the table top
      send_request(12'd2048, 16'sd8192, -16'sd4096);
      send_request(12'd3072, 16'sd8192, -16'sd4096);
      send_request(12'd4095, -16'sd8192, 16'sd4096);
      send_request(12'd16,   -16'sd8192, 16'sd4096);  // mid-step interpolation
      settle();
      write_reg(REG_PAIR_COUNT, 32'd0);               // electrical angle pinned to zero
      send_request(12'd1234, 16'sd20000, 16'sd3000);
      send_request(12'd3000, -16'sd20000, 16'sd3000);
      settle();
      write_reg(REG_PAIR_COUNT, 32'd127);
      write_reg(REG_REVERSE, 32'd1);
      write_reg(REG_ZERO_OFFSET, 32'd4095);
      send_request(12'd0,    16'sd10000, 16'sd10000);
      send_request(12'd4095, 16'sd10000, -16'sd10000);
      send_request(12'd2000, -16'sd10000, 16'sd10000);
      settle();
      write_reg(UNUSED_REG_INDEX, 32'hFFFF_FFFF);      // must leave all settings alone
      send_request(12'd777, 16'sd5000, 16'sd5000);
   endtask

   // Mostly rotating sweeps with random speed, plus random angle jumps.
   // Reconfigure every so often after letting the pipe drain.
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      int enc_pos;
      int speed;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      enc_pos = $urandom_range(4095);
      speed   = int'($urandom_range(2000)) - 1000;
      for (int n = 0; n < count; n++) begin
         if (n % 165 == 0) begin
            settle();
            randomize_config();
         end
         if ($urandom_range(29) == 0) begin
            speed = int'($urandom_range(2000)) - 1000;
         end
         if ($urandom_range(9) < 8) begin
            enc_pos = (enc_pos + speed + 4096) % 4096;
         end else begin
            enc_pos = $urandom_range(4095);
         end
         send_request(ANGLE_W'(enc_pos), pick_volt(), pick_volt());
      end
   endtask

   initial begin
      // Drive every input to a known value before the first edge
      req_bus.valid         = 1'b0;
      req_bus.encoder_count = '0;
      req_bus.volt_q        = '0;
      req_bus.volt_d        = '0;
      rsp_bus.ready         = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;

      // Shadow state matches the block right out of reset
      pair_count_now  = PAIR_COUNT_RESET;
      reverse_now     = REVERSE_RESET;
      zero_offset_now = ZERO_OFFSET_RESET;
      prev_angle      = '0;
      turn_total      = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_turn_tracking();
      test_register_corners();
      test_random_traffic(25, 86, 665);
      test_random_traffic(86, 25, 665);
      test_random_traffic(0, 0, 665);

      // Let the last responses out, then watch for strays over a latency window
      settle();
      repeat (40) @(posedge clock);

      $display("Covered %0d requests, %0d responses and %0d register writes;", requests_sent,
               results_checked, reg_writes);
      $display("turn stepping, all register corners and three stall profiles were exercised.");
      if (error_count == 0 && pwm_queue.size() == 0) begin
         $display("tb_foc_voltage_modulator: done, clean");
      end else begin
         $display("%0d mismatches, %0d responses still missing", error_count, pwm_queue.size());
         $display("tb_foc_voltage_modulator: done, errors");
      end
      $finish;
   end

endmodule
